### design/avr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package avr_pkg;

   localparam int DATA_WIDTH_DEF   = 16;
   localparam int CORDIC_STEPS_DEF = 14;

   // CORDIC works in Q2.29, carried in ANG_WIDTH (34) bits with guard bits
   localparam int INT_FRAC   = 29;
   localparam int ANG_WIDTH  = 34;
   localparam int ATAN_COUNT = 30;

   localparam logic signed [ANG_WIDTH-1:0] PI_Q29      = 34'sd1686629713;
   localparam logic signed [ANG_WIDTH-1:0] HALF_PI_Q29 = 34'sd843314856;
   localparam logic signed [ANG_WIDTH-1:0] KINV_Q29    = 34'sd326016437;

   localparam logic signed [ANG_WIDTH-1:0] ATAN_TABLE [ATAN_COUNT] = '{
      34'sd421657428, 34'sd248918915, 34'sd131521918, 34'sd66762579, 34'sd33510843,
      34'sd16771758,  34'sd8387925,   34'sd4194219,   34'sd2097141,  34'sd1048575,
      34'sd524288,    34'sd262144,    34'sd131072,    34'sd65536,    34'sd32768,
      34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,     34'sd1024,
      34'sd512,       34'sd256,       34'sd128,       34'sd64,       34'sd32,
      34'sd16,        34'sd8,         34'sd4,         34'sd2,        34'sd1
   };

   // rotated vector grows by this many bits over the data width
   localparam int R_EXTRA = 4;
   // normalization target: largest magnitude in [2^29, 2^30)
   localparam int NORM_MSB   = 29;
   localparam int MAG_WIDTH  = 31;
   localparam int SUM_WIDTH  = 62;
   localparam int ROOT_WIDTH = 31;

   function automatic logic signed [63:0] sat_w(input logic signed [63:0] v, input int w);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (w - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic logic signed [63:0] round_sh(input logic signed [63:0] v, input int s);
      logic signed [63:0] r;
      if (s == 0) r = v;
      else r = (v + (64'sd1 <<< (s - 1))) >>> s;
      return r;
   endfunction

endpackage
`default_nettype wire

### design/avr_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface avr_req_if #(parameter int W = avr_pkg::DATA_WIDTH_DEF);
   logic         valid;
   logic         ready;
   logic [W-1:0] vec_x;
   logic [W-1:0] vec_y;
   logic [W-1:0] vec_z;
   logic [W-1:0] rot_angle;
   logic [W-1:0] axis_x;
   logic [W-1:0] axis_y;
   logic [W-1:0] axis_z;

   modport source (output valid, vec_x, vec_y, vec_z, rot_angle, axis_x, axis_y, axis_z,
                   input ready);
   modport sink   (input valid, vec_x, vec_y, vec_z, rot_angle, axis_x, axis_y, axis_z,
                   output ready);
endinterface
`default_nettype wire

### design/avr_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface avr_rsp_if #(parameter int W = avr_pkg::DATA_WIDTH_DEF);
   logic         valid;
   logic         ready;
   logic [W-1:0] out_x;
   logic [W-1:0] out_y;
   logic [W-1:0] out_z;
   logic         zero_length;

   modport source (output valid, out_x, out_y, out_z, zero_length, input ready);
   modport sink   (input valid, out_x, out_y, out_z, zero_length, output ready);
endinterface
`default_nettype wire

### design/axis_angle_vector_rotate.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one beat per cycle while rsp_chan accepts; every stage is registered, so a new
// vector enters each cycle unless the output register holds a beat the sink has not taken.
// The depth is set by the CORDIC iterations, the 31-stage square root and the
// DATA_WIDTH - 1 stage divider; all of them are fully pipelined.
// Reset: synchronous, active high; clears every stage valid bit, payload is not reset.
module axis_angle_vector_rotate #(
   parameter int DATA_WIDTH   = avr_pkg::DATA_WIDTH_DEF,
   parameter int CORDIC_STEPS = avr_pkg::CORDIC_STEPS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   avr_req_if.sink   req_chan,
   avr_rsp_if.source rsp_chan
);
   import avr_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int F  = W - 3;
   localparam int RW = W + R_EXTRA;
   localparam int ONE_Q = 1 << F;

   // Whole pipeline advances together; it holds only while the output
   // register carries a beat the sink has not taken.
   logic en;
   logic out_valid;

   assign en             = !out_valid || rsp_chan.ready;
   assign req_chan.ready = en;

   // sin/cos of the folded angle
   logic              cor_valid;
   logic [2:0][W-1:0] cor_vec, cor_axis;
   logic [W-1:0]      cor_cos, cor_sin, cor_omc;

   avr_cordic #(.W(W), .N(CORDIC_STEPS)) u_cordic (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_chan.valid),
      .vec      ({req_chan.vec_z, req_chan.vec_y, req_chan.vec_x}),
      .axis     ({req_chan.axis_z, req_chan.axis_y, req_chan.axis_x}),
      .angle    (req_chan.rot_angle),
      .out_valid(cor_valid),
      .vec_out  (cor_vec),
      .axis_out (cor_axis),
      .cos_out  (cor_cos),
      .sin_out  (cor_sin),
      .omc_out  (cor_omc)
   );

   // Rodrigues matrix built and applied
   logic               mat_valid;
   logic [2:0][RW-1:0] mat_rot;

   avr_matrix #(.W(W)) u_matrix (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (cor_valid),
      .vec      (cor_vec),
      .axis     (cor_axis),
      .cos_in   (cor_cos),
      .sin_in   (cor_sin),
      .omc_in   (cor_omc),
      .out_valid(mat_valid),
      .rot      (mat_rot)
   );

   // scale into [2^29, 2^30), sum of squares
   logic                      nrm_valid;
   logic [SUM_WIDTH-1:0]      nrm_sum;
   logic [2:0][MAG_WIDTH-1:0] nrm_mag;
   logic [2:0]                nrm_neg;
   logic                      nrm_zero;

   avr_norm #(.W(W)) u_norm (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (mat_valid),
      .rot      (mat_rot),
      .out_valid(nrm_valid),
      .sum_out  (nrm_sum),
      .mag_out  (nrm_mag),
      .neg_out  (nrm_neg),
      .zero_out (nrm_zero)
   );

   // floor square root = length
   logic                      sq_valid;
   logic [ROOT_WIDTH-1:0]     sq_root;
   logic [2:0][MAG_WIDTH-1:0] sq_mag;
   logic [2:0]                sq_neg;
   logic                      sq_zero;

   avr_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (nrm_valid),
      .sum_in   (nrm_sum),
      .mag_in   (nrm_mag),
      .neg_in   (nrm_neg),
      .zero_in  (nrm_zero),
      .out_valid(sq_valid),
      .root_out (sq_root),
      .mag_out  (sq_mag),
      .neg_out  (sq_neg),
      .zero_out (sq_zero)
   );

   // rounded quotient per component; last register is the rsp register
   logic [2:0][W-1:0] div_res;
   logic              div_zero;

   avr_div #(.W(W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (sq_valid),
      .root_in  (sq_root),
      .mag_in   (sq_mag),
      .neg_in   (sq_neg),
      .zero_in  (sq_zero),
      .out_valid(out_valid),
      .res_out  (div_res),
      .zero_out (div_zero)
   );

   assign rsp_chan.valid       = out_valid;
   assign rsp_chan.out_x       = div_res[0];
   assign rsp_chan.out_y       = div_res[1];
   assign rsp_chan.out_z       = div_res[2];
   assign rsp_chan.zero_length = div_zero;

   // zero-length beats carry a zero vector
   a_zero_vec: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.zero_length |->
         rsp_chan.out_x == '0 && rsp_chan.out_y == '0 && rsp_chan.out_z == '0)
      else $error("zero_length beat with nonzero vector");

   // normalized beats always have a nonzero component
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.zero_length |->
         rsp_chan.out_x != '0 || rsp_chan.out_y != '0 || rsp_chan.out_z != '0)
      else $error("normalized beat is all zero");

   // unit vector components stay within [-1, 1]
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         $signed(rsp_chan.out_x) <= ONE_Q && $signed(rsp_chan.out_x) >= -ONE_Q &&
         $signed(rsp_chan.out_y) <= ONE_Q && $signed(rsp_chan.out_y) >= -ONE_Q &&
         $signed(rsp_chan.out_z) <= ONE_Q && $signed(rsp_chan.out_z) >= -ONE_Q)
      else $error("output component beyond unit range");

   // reset flushes the pipe
   a_reset_flush: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_chan.valid)
      else $error("rsp valid right after reset");

endmodule
`default_nettype wire

### design/avr_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module avr_cordic #(
   parameter int W = avr_pkg::DATA_WIDTH_DEF,
   parameter int N = avr_pkg::CORDIC_STEPS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [2:0][W-1:0] vec,
   input  logic [2:0][W-1:0] axis,
   input  logic [W-1:0]      angle,
   output logic              out_valid,
   output logic [2:0][W-1:0] vec_out,
   output logic [2:0][W-1:0] axis_out,
   output logic [W-1:0]      cos_out,
   output logic [W-1:0]      sin_out,
   output logic [W-1:0]      omc_out
);
   import avr_pkg::*;

   localparam int F  = W - 3;
   localparam int SH = INT_FRAC - F;
   localparam int AW = ANG_WIDTH;

   logic signed [AW-1:0] cx_ff [0:N];
   logic signed [AW-1:0] cy_ff [0:N];
   logic signed [AW-1:0] z_ff  [0:N];
   logic                 flip_ff  [0:N];
   logic                 valid_ff [0:N];
   logic [2:0][W-1:0]    vec_ff   [0:N];
   logic [2:0][W-1:0]    axis_ff  [0:N];

   logic signed [AW-1:0] ang_in;
   logic                 flip_in;

   // quadrant fold into [-pi/2, pi/2]
   always_comb begin
      logic signed [AW-1:0] a;
      a = AW'($signed(angle)) <<< SH;
      flip_in = 1'b0;
      ang_in  = a;
      if (a > HALF_PI_Q29) begin
         ang_in  = a - PI_Q29;
         flip_in = 1'b1;
      end else if (a < -HALF_PI_Q29) begin
         ang_in  = a + PI_Q29;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff[0] <= 1'b0;
      else if (en) valid_ff[0] <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff[0]   <= KINV_Q29;
         cy_ff[0]   <= '0;
         z_ff[0]    <= ang_in;
         flip_ff[0] <= flip_in;
         vec_ff[0]  <= vec;
         axis_ff[0] <= axis;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_iter
      logic signed [AW-1:0] cx_in, cy_in, z_in;

      always_comb begin
         logic signed [AW-1:0] dx, dy;
         dx = cy_ff[i] >>> i;
         dy = cx_ff[i] >>> i;
         if (z_ff[i] >= 0) begin
            cx_in = cx_ff[i] - dx;
            cy_in = cy_ff[i] + dy;
            z_in  = z_ff[i] - ATAN_TABLE[i];
         end else begin
            cx_in = cx_ff[i] + dx;
            cy_in = cy_ff[i] - dy;
            z_in  = z_ff[i] + ATAN_TABLE[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) valid_ff[i+1] <= 1'b0;
         else if (en) valid_ff[i+1] <= valid_ff[i];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            cx_ff[i+1]   <= cx_in;
            cy_ff[i+1]   <= cy_in;
            z_ff[i+1]    <= z_in;
            flip_ff[i+1] <= flip_ff[i];
            vec_ff[i+1]  <= vec_ff[i];
            axis_ff[i+1] <= axis_ff[i];
         end
      end
   end

   // round to Q3.F, undo the fold, build 1 - cos
   logic [W-1:0] cos_in, sin_in, omc_in;

   always_comb begin
      logic signed [AW-1:0] xf, yf;
      logic signed [63:0]   c64, s64, t64;
      xf = flip_ff[N] ? -cx_ff[N] : cx_ff[N];
      yf = flip_ff[N] ? -cy_ff[N] : cy_ff[N];
      c64 = sat_w(round_sh(64'(xf), SH), W);
      s64 = sat_w(round_sh(64'(yf), SH), W);
      t64 = sat_w((64'sd1 <<< F) - c64, W);
      cos_in = c64[W-1:0];
      sin_in = s64[W-1:0];
      omc_in = t64[W-1:0];
   end

   logic              valid_r_ff;
   logic [W-1:0]      cos_ff, sin_ff, omc_ff;
   logic [2:0][W-1:0] vec_r_ff, axis_r_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_r_ff <= 1'b0;
      else if (en) valid_r_ff <= valid_ff[N];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff    <= cos_in;
         sin_ff    <= sin_in;
         omc_ff    <= omc_in;
         vec_r_ff  <= vec_ff[N];
         axis_r_ff <= axis_ff[N];
      end
   end

   assign out_valid = valid_r_ff;
   assign vec_out   = vec_r_ff;
   assign axis_out  = axis_r_ff;
   assign cos_out   = cos_ff;
   assign sin_out   = sin_ff;
   assign omc_out   = omc_ff;

endmodule
`default_nettype wire

### design/avr_matrix.sv
`timescale 1ns / 1ps
`default_nettype none
module avr_matrix #(
   parameter int W = avr_pkg::DATA_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic [2:0][W-1:0]                     vec,
   input  logic [2:0][W-1:0]                     axis,
   input  logic [W-1:0]                          cos_in,
   input  logic [W-1:0]                          sin_in,
   input  logic [W-1:0]                          omc_in,
   output logic                                  out_valid,
   output logic [2:0][W+avr_pkg::R_EXTRA-1:0]    rot
);
   import avr_pkg::*;

   localparam int F  = W - 3;
   localparam int RW = W + R_EXTRA;
   localparam int PW = 2 * W;

   logic [5:0] valid_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (en) valid_ff <= {valid_ff[4:0], in_valid};
   end

   // M1: axis outer product and axis * sin
   logic signed [PW-1:0] p1_ff  [3][3];
   logic signed [PW-1:0] ps1_ff [3];
   logic [W-1:0]         c1_ff, t1_ff;
   logic [2:0][W-1:0]    v1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) p1_ff[i][j] <= $signed(axis[i]) * $signed(axis[j]);
            ps1_ff[i] <= $signed(axis[i]) * $signed(sin_in);
         end
         c1_ff <= cos_in;
         t1_ff <= omc_in;
         v1_ff <= vec;
      end
   end

   // M2: round and saturate
   logic signed [W-1:0] q2_in [3][3];
   logic signed [W-1:0] qs2_in [3];

   always_comb begin
      logic signed [63:0] tmp;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            tmp = sat_w(round_sh(64'(p1_ff[i][j]), F), W);
            q2_in[i][j] = tmp[W-1:0];
         end
         tmp = sat_w(round_sh(64'(ps1_ff[i]), F), W);
         qs2_in[i] = tmp[W-1:0];
      end
   end

   logic signed [W-1:0] q2_ff [3][3];
   logic signed [W-1:0] qs2_ff [3];
   logic [W-1:0]        c2_ff, t2_ff;
   logic [2:0][W-1:0]   v2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         q2_ff  <= q2_in;
         qs2_ff <= qs2_in;
         c2_ff  <= c1_ff;
         t2_ff  <= t1_ff;
         v2_ff  <= v1_ff;
      end
   end

   // M3: times (1 - cos)
   logic signed [PW-1:0] mt3_ff [3][3];
   logic signed [W-1:0]  qs3_ff [3];
   logic [W-1:0]         c3_ff;
   logic [2:0][W-1:0]    v3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) mt3_ff[i][j] <= q2_ff[i][j] * $signed(t2_ff);
         qs3_ff <= qs2_ff;
         c3_ff  <= c2_ff;
         v3_ff  <= v2_ff;
      end
   end

   // M4: matrix entries; cos on the diagonal, cross-product terms off it
   logic signed [W-1:0] m4_in [3][3];

   always_comb begin
      logic signed [63:0] base, tmp;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            base = sat_w(round_sh(64'(mt3_ff[i][j]), F), W);
            if (i == j) tmp = sat_w(base + 64'($signed(c3_ff)), W);
            else if (j == (i + 2) % 3) tmp = sat_w(base + 64'(qs3_ff[3-i-j]), W);
            else tmp = sat_w(base - 64'(qs3_ff[3-i-j]), W);
            m4_in[i][j] = tmp[W-1:0];
         end
      end
   end

   logic signed [W-1:0] m4_ff [3][3];
   logic [2:0][W-1:0]   v4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         m4_ff <= m4_in;
         v4_ff <= v3_ff;
      end
   end

   // M5: row-by-vector products
   logic signed [PW-1:0] mv5_ff [3][3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) mv5_ff[i][j] <= m4_ff[i][j] * $signed(v4_ff[j]);
      end
   end

   // M6: row sums, no saturation
   logic [2:0][RW-1:0] r6_in;

   always_comb begin
      logic signed [63:0] acc;
      for (int i = 0; i < 3; i++) begin
         acc = round_sh(64'(mv5_ff[i][0]), F) + round_sh(64'(mv5_ff[i][1]), F)
             + round_sh(64'(mv5_ff[i][2]), F);
         r6_in[i] = acc[RW-1:0];
      end
   end

   logic [2:0][RW-1:0] r6_ff;

   always_ff @(posedge clock) begin
      if (en) r6_ff <= r6_in;
   end

   assign out_valid = valid_ff[5];
   assign rot       = r6_ff;

endmodule
`default_nettype wire

### design/avr_norm.sv
`timescale 1ns / 1ps
`default_nettype none
module avr_norm #(
   parameter int W = avr_pkg::DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [2:0][W+avr_pkg::R_EXTRA-1:0]  rot,
   output logic                                out_valid,
   output logic [avr_pkg::SUM_WIDTH-1:0]       sum_out,
   output logic [2:0][avr_pkg::MAG_WIDTH-1:0]  mag_out,
   output logic [2:0]                          neg_out,
   output logic                                zero_out
);
   import avr_pkg::*;

   localparam int RW = W + R_EXTRA;
   localparam int PW = $clog2(RW);
   localparam int MW = MAG_WIDTH;
   localparam int SW = SUM_WIDTH;

   logic [4:0] valid_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (en) valid_ff <= {valid_ff[3:0], in_valid};
   end

   // N1: largest magnitude
   logic [RW-1:0] big_in;

   always_comb begin
      logic [RW-1:0] m;
      big_in = '0;
      for (int i = 0; i < 3; i++) begin
         m = rot[i][RW-1] ? RW'(-$signed(rot[i])) : rot[i];
         if (m > big_in) big_in = m;
      end
   end

   logic [2:0][RW-1:0] r1_ff;
   logic [RW-1:0]      big1_ff;
   logic               zero1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         r1_ff    <= rot;
         big1_ff  <= big_in;
         zero1_ff <= (big_in == '0);
      end
   end

   // N2: leading one of the largest magnitude
   logic [PW-1:0] pos_in;

   always_comb begin
      pos_in = '0;
      for (int b = 0; b < RW; b++)
         if (big1_ff[b]) pos_in = PW'(b);
   end

   logic [2:0][RW-1:0] r2_ff;
   logic [PW-1:0]      pos2_ff;
   logic               zero2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         r2_ff    <= r1_ff;
         pos2_ff  <= pos_in;
         zero2_ff <= zero1_ff;
      end
   end

   // N3: power-of-two scaling, right shifts floor
   logic signed [31:0] rs3_in [3];

   always_comb begin
      logic signed [63:0] t;
      for (int i = 0; i < 3; i++) begin
         if (int'(pos2_ff) < NORM_MSB)
            t = 64'($signed(r2_ff[i])) <<< (NORM_MSB - int'(pos2_ff));
         else
            t = 64'($signed(r2_ff[i])) >>> (int'(pos2_ff) - NORM_MSB);
         rs3_in[i] = t[31:0];
      end
   end

   logic signed [31:0] rs3_ff [3];
   logic               zero3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rs3_ff   <= rs3_in;
         zero3_ff <= zero2_ff;
      end
   end

   // N4: magnitudes and squares
   logic [2:0][MW-1:0] mag4_in;

   always_comb begin
      for (int i = 0; i < 3; i++)
         mag4_in[i] = rs3_ff[i][31] ? MW'(-rs3_ff[i]) : MW'(rs3_ff[i]);
   end

   logic [SW-1:0]      sq4_ff [3];
   logic [2:0][MW-1:0] mag4_ff;
   logic [2:0]         neg4_ff;
   logic               zero4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq4_ff[i]  <= mag4_in[i] * mag4_in[i];
            neg4_ff[i] <= rs3_ff[i][31];
         end
         mag4_ff  <= mag4_in;
         zero4_ff <= zero3_ff;
      end
   end

   // N5: sum of squares
   logic [SW-1:0]      sum5_ff;
   logic [2:0][MW-1:0] mag5_ff;
   logic [2:0]         neg5_ff;
   logic               zero5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sum5_ff  <= sq4_ff[0] + sq4_ff[1] + sq4_ff[2];
         mag5_ff  <= mag4_ff;
         neg5_ff  <= neg4_ff;
         zero5_ff <= zero4_ff;
      end
   end

   assign out_valid = valid_ff[4];
   assign sum_out   = sum5_ff;
   assign mag_out   = mag5_ff;
   assign neg_out   = neg5_ff;
   assign zero_out  = zero5_ff;

endmodule
`default_nettype wire

### design/avr_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module avr_sqrt (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [avr_pkg::SUM_WIDTH-1:0]       sum_in,
   input  logic [2:0][avr_pkg::MAG_WIDTH-1:0]  mag_in,
   input  logic [2:0]                          neg_in,
   input  logic                                zero_in,
   output logic                                out_valid,
   output logic [avr_pkg::ROOT_WIDTH-1:0]      root_out,
   output logic [2:0][avr_pkg::MAG_WIDTH-1:0]  mag_out,
   output logic [2:0]                          neg_out,
   output logic                                zero_out
);
   import avr_pkg::*;

   localparam int RB  = ROOT_WIDTH;
   localparam int SW  = SUM_WIDTH;
   localparam int MW  = MAG_WIDTH;
   localparam int REW = RB + 2;

   logic [SW-1:0]      rad_ff  [0:RB];
   logic [REW-1:0]     rem_ff  [0:RB];
   logic [RB-1:0]      root_ff [0:RB];
   logic [2:0][MW-1:0] mag_ff  [0:RB];
   logic [2:0]         neg_ff  [0:RB];
   logic               zero_ff [0:RB];
   logic               valid_ff [0:RB];

   always_ff @(posedge clock) begin
      if (reset) valid_ff[0] <= 1'b0;
      else if (en) valid_ff[0] <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff[0]  <= sum_in;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         mag_ff[0]  <= mag_in;
         neg_ff[0]  <= neg_in;
         zero_ff[0] <= zero_in;
      end
   end

   // one root bit per stage, two radicand bits in
   for (genvar k = 0; k < RB; k++) begin : g_digit
      logic [REW-1:0] rem_in;
      logic [RB-1:0]  root_in;

      always_comb begin
         logic [REW-1:0] remx, trial;
         remx  = {rem_ff[k][REW-3:0], rad_ff[k][SW-1:SW-2]};
         trial = {root_ff[k], 2'b01};
         if (remx >= trial) begin
            rem_in  = remx - trial;
            root_in = {root_ff[k][RB-2:0], 1'b1};
         end else begin
            rem_in  = remx;
            root_in = {root_ff[k][RB-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) valid_ff[k+1] <= 1'b0;
         else if (en) valid_ff[k+1] <= valid_ff[k];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k+1]  <= {rad_ff[k][SW-3:0], 2'b00};
            rem_ff[k+1]  <= rem_in;
            root_ff[k+1] <= root_in;
            mag_ff[k+1]  <= mag_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            zero_ff[k+1] <= zero_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[RB];
   assign root_out  = root_ff[RB];
   assign mag_out   = mag_ff[RB];
   assign neg_out   = neg_ff[RB];
   assign zero_out  = zero_ff[RB];

endmodule
`default_nettype wire

### design/avr_div.sv
`timescale 1ns / 1ps
`default_nettype none
module avr_div #(
   parameter int W = avr_pkg::DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [avr_pkg::ROOT_WIDTH-1:0]      root_in,
   input  logic [2:0][avr_pkg::MAG_WIDTH-1:0]  mag_in,
   input  logic [2:0]                          neg_in,
   input  logic                                zero_in,
   output logic                                out_valid,
   output logic [2:0][W-1:0]                   res_out,
   output logic                                zero_out
);
   import avr_pkg::*;

   localparam int F  = W - 3;
   localparam int QB = F + 2;
   localparam int DW = W + 31;

   logic [DW-1:0]   rem_ff [0:QB][3];
   logic [QB-1:0]   q_ff   [0:QB][3];
   logic [DW-1:0]   den_ff [0:QB];
   logic [2:0]      neg_ff [0:QB];
   logic            zero_ff [0:QB];
   logic            valid_ff [0:QB];

   always_ff @(posedge clock) begin
      if (reset) valid_ff[0] <= 1'b0;
      else if (en) valid_ff[0] <= in_valid;
   end

   // dividend |r| * 2^F + len / 2
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            rem_ff[0][i] <= (DW'(mag_in[i]) << F) + DW'(root_in >> 1);
            q_ff[0][i]   <= '0;
         end
         den_ff[0]  <= DW'(root_in);
         neg_ff[0]  <= neg_in;
         zero_ff[0] <= zero_in;
      end
   end

   // restoring division, one quotient bit per stage, three lanes
   for (genvar j = 0; j < QB; j++) begin : g_bit
      logic [DW-1:0] rem_in [3];
      logic [QB-1:0] q_in   [3];

      always_comb begin
         logic [DW-1:0] trial;
         trial = den_ff[j] << (QB - 1 - j);
         for (int i = 0; i < 3; i++) begin
            if (rem_ff[j][i] >= trial) begin
               rem_in[i] = rem_ff[j][i] - trial;
               q_in[i]   = {q_ff[j][i][QB-2:0], 1'b1};
            end else begin
               rem_in[i] = rem_ff[j][i];
               q_in[i]   = {q_ff[j][i][QB-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) valid_ff[j+1] <= 1'b0;
         else if (en) valid_ff[j+1] <= valid_ff[j];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1]  <= rem_in;
            q_ff[j+1]    <= q_in;
            den_ff[j+1]  <= den_ff[j];
            neg_ff[j+1]  <= neg_ff[j];
            zero_ff[j+1] <= zero_ff[j];
         end
      end
   end

   // sign and zero forcing; quotient never exceeds 2^F
   logic [2:0][W-1:0] res_in;

   always_comb begin
      logic [W-1:0] q;
      for (int i = 0; i < 3; i++) begin
         q = W'(q_ff[QB][i]);
         if (zero_ff[QB]) res_in[i] = '0;
         else if (neg_ff[QB][i]) res_in[i] = -q;
         else res_in[i] = q;
      end
   end

   logic              valid_o_ff;
   logic [2:0][W-1:0] res_ff;
   logic              zero_o_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_o_ff <= 1'b0;
      else if (en) valid_o_ff <= valid_ff[QB];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff    <= res_in;
         zero_o_ff <= zero_ff[QB];
      end
   end

   assign out_valid = valid_o_ff;
   assign res_out   = res_ff;
   assign zero_out  = zero_o_ff;

endmodule
`default_nettype wire

### tb/avr_rotate_checker.sv
`timescale 1ns / 1ps
module avr_rotate_checker (
   input  logic     clock,
   input  logic     reset,
   avr_req_if       req_mon,
   avr_rsp_if       rsp_mon,
   output int       fail_count,
   output int       pending
);
   import avr_pkg::*;

   localparam int W     = DATA_WIDTH_DEF;
   localparam int FB    = W - 3;
   localparam int STEPS = CORDIC_STEPS_DEF;

   typedef struct packed {
      logic [W-1:0] out_x;
      logic [W-1:0] out_y;
      logic [W-1:0] out_z;
      logic         zero_length;
   } unit_vec_type;

   unit_vec_type unit_vec_q[$];

   function automatic longint sat_dw(longint v);
      longint hi;
      hi = (64'sd1 <<< (W - 1)) - 1;
      return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
   endfunction

   function automatic longint rnd_sh(longint v, int s);
      if (s == 0) return v;
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint fx_mul(longint a, longint b);
      return sat_dw(rnd_sh(a * b, FB));
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned res, bit_w;
      res   = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > n) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (n >= res + bit_w) begin
            n   = n - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   // rotate the vector about the axis, then scale to unit length
   function automatic unit_vec_type rotate_unit(logic signed [W-1:0] vx,
                                                logic signed [W-1:0] vy,
                                                logic signed [W-1:0] vz,
                                                logic signed [W-1:0] ang_in,
                                                logic signed [W-1:0] ax,
                                                logic signed [W-1:0] ay,
                                                logic signed [W-1:0] az);
      longint v[3], a[3], r[3], m[3][3];
      longint ang, cx, cy, zr, dx, dy, c, s, t, big, q;
      longint unsigned sum, len, num;
      bit flip;
      int sh;
      unit_vec_type res;
      v[0] = vx; v[1] = vy; v[2] = vz;
      a[0] = ax; a[1] = ay; a[2] = az;
      flip = 0;
      ang  = longint'(ang_in) <<< (INT_FRAC - FB);
      if (ang > HALF_PI_Q29) begin
         ang  = ang - PI_Q29;
         flip = 1;
      end else if (ang < -longint'(HALF_PI_Q29)) begin
         ang  = ang + PI_Q29;
         flip = 1;
      end
      cx = KINV_Q29;
      cy = 0;
      zr = ang;
      for (int i = 0; i < STEPS && i < ATAN_COUNT; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (zr >= 0) begin
            cx = cx - dx; cy = cy + dy; zr = zr - ATAN_TABLE[i];
         end else begin
            cx = cx + dx; cy = cy - dy; zr = zr + ATAN_TABLE[i];
         end
      end
      if (flip) begin
         cx = -cx;
         cy = -cy;
      end
      c = sat_dw(rnd_sh(cx, INT_FRAC - FB));
      s = sat_dw(rnd_sh(cy, INT_FRAC - FB));
      t = sat_dw((64'sd1 <<< FB) - c);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            m[i][j] = fx_mul(fx_mul(a[i], a[j]), t);
      for (int i = 0; i < 3; i++) m[i][i] = sat_dw(m[i][i] + c);
      m[0][1] = sat_dw(m[0][1] - fx_mul(a[2], s));
      m[0][2] = sat_dw(m[0][2] + fx_mul(a[1], s));
      m[1][0] = sat_dw(m[1][0] + fx_mul(a[2], s));
      m[1][2] = sat_dw(m[1][2] - fx_mul(a[0], s));
      m[2][0] = sat_dw(m[2][0] - fx_mul(a[1], s));
      m[2][1] = sat_dw(m[2][1] + fx_mul(a[0], s));
      big = 0;
      for (int i = 0; i < 3; i++) begin
         r[i] = rnd_sh(m[i][0] * v[0], FB) + rnd_sh(m[i][1] * v[1], FB)
              + rnd_sh(m[i][2] * v[2], FB);
         if ((r[i] < 0 ? -r[i] : r[i]) > big) big = r[i] < 0 ? -r[i] : r[i];
      end
      res = '0;
      if (big == 0) begin
         res.zero_length = 1'b1;
         return res;
      end
      sh = 0;
      while (big < (64'sd1 <<< 29)) begin big = big * 2; sh++; end
      while (big >= (64'sd1 <<< 30)) begin big = big >>> 1; sh--; end
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         if (sh > 0) r[i] = r[i] <<< sh;
         else if (sh < 0) r[i] = r[i] >>> (-sh);
         sum = sum + longint'(r[i] * r[i]);
      end
      len = floor_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         num = (longint'(r[i] < 0 ? -r[i] : r[i]) << FB) + (len >> 1);
         q   = longint'(num / len);
         if (r[i] < 0) q = -q;
         q = sat_dw(q);
         if (i == 0) res.out_x = q[W-1:0];
         else if (i == 1) res.out_y = q[W-1:0];
         else res.out_z = q[W-1:0];
      end
      return res;
   endfunction

   assign pending = unit_vec_q.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      unit_vec_type want, got;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            unit_vec_q.push_back(rotate_unit(req_mon.vec_x, req_mon.vec_y, req_mon.vec_z,
                                             req_mon.rot_angle, req_mon.axis_x,
                                             req_mon.axis_y, req_mon.axis_z));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.out_x, rsp_mon.out_y, rsp_mon.out_z, rsp_mon.zero_length};
            if (unit_vec_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("rsp beat with nothing expected: %h", got);
            end else begin
               want = unit_vec_q.pop_front();
               if (want != got) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: exp x=%h y=%h z=%h zl=%b  got x=%h y=%h z=%h zl=%b",
                              want.out_x, want.out_y, want.out_z, want.zero_length,
                              got.out_x, got.out_y, got.out_z, got.zero_length);
               end
            end
         end
      end
   end
endmodule

### tb/tb_axis_angle_vector_rotate.sv
`timescale 1ns / 1ps
module tb_axis_angle_vector_rotate;
   import avr_pkg::*;

   localparam int W          = DATA_WIDTH_DEF;
   localparam int N_RANDOM   = 2000;
   localparam int DRAIN_WAIT = CORDIC_STEPS_DEF + DATA_WIDTH_DEF + 46 + 20;
   localparam logic [W-1:0] ONE_Q   = 16'sd8192;   // 1.0 in Q3.13
   localparam logic [W-1:0] M_ONE_Q = -16'sd8192;
   localparam logic [W-1:0] MAX_Q   = 16'h7fff;
   localparam logic [W-1:0] MIN_Q   = 16'h8000;
   localparam logic [W-1:0] HALF_PI = 16'sd12868;  // just above pi/2

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   bit   rsp_stall_on = 1'b1;

   avr_req_if #(W) req_chan ();
   avr_rsp_if #(W) rsp_chan ();

   axis_angle_vector_rotate u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   avr_rotate_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #6 clock = ~clock;

   // random gap length: mostly none or short, now and then long
   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) return 0;
      if (pick < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // result side back-pressure, driven at the falling edge
   initial begin
      int hold;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!rsp_stall_on) begin
            rsp_chan.ready = 1'b1;
         end else if (hold > 0) begin
            hold--;
         end else begin
            hold = gap_len();
            rsp_chan.ready = (hold == 0);
         end
      end
   end

   // one req beat; valid stays high when no gap is drawn
   task automatic send_beat(input logic [W-1:0] vx, vy, vz, ang, ax, ay, az, input int gap);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid     = 1'b1;
      req_chan.vec_x     = vx;
      req_chan.vec_y     = vy;
      req_chan.vec_z     = vz;
      req_chan.rot_angle = ang;
      req_chan.axis_x    = ax;
      req_chan.axis_y    = ay;
      req_chan.axis_z    = az;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // random axis: mostly unit axes along a coordinate, some arbitrary
   task automatic rand_axis(output logic [W-1:0] ax, ay, az);
      int pick;
      pick = $urandom_range(0, 9);
      ax = '0; ay = '0; az = '0;
      if (pick < 6) begin
         case ($urandom_range(0, 2))
            0: ax = $urandom_range(0, 1) ? ONE_Q : M_ONE_Q;
            1: ay = $urandom_range(0, 1) ? ONE_Q : M_ONE_Q;
            default: az = $urandom_range(0, 1) ? ONE_Q : M_ONE_Q;
         endcase
      end else if (pick < 8) begin
         // roughly unit diagonal-ish axes, components up to about 0.6
         ax = 16'($signed($urandom_range(0, 10000)) - 5000);
         ay = 16'($signed($urandom_range(0, 10000)) - 5000);
         az = 16'($signed($urandom_range(0, 10000)) - 5000);
      end else begin
         ax = $urandom; ay = $urandom; az = $urandom;
      end
   endtask

   initial begin
      logic [W-1:0] ax, ay, az, vx, vy, vz, ang;
      req_chan.valid     = 1'b0;
      req_chan.vec_x     = '0;
      req_chan.vec_y     = '0;
      req_chan.vec_z     = '0;
      req_chan.rot_angle = '0;
      req_chan.axis_x    = '0;
      req_chan.axis_y    = '0;
      req_chan.axis_z    = '0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // directed: zero vector, zero angle, field extremes, quadrant fold
      send_beat('0, '0, '0, '0, ONE_Q, '0, '0, 0);              // zero-length result
      send_beat(ONE_Q, '0, '0, '0, '0, '0, ONE_Q, 0);
      send_beat(ONE_Q, '0, '0, 16'sd6434, '0, '0, ONE_Q, 0);    // eighth turn about z
      send_beat(ONE_Q, ONE_Q, '0, HALF_PI, '0, '0, ONE_Q, 1);   // just past pi/2: fold
      send_beat(ONE_Q, ONE_Q, '0, -HALF_PI, '0, '0, ONE_Q, 0);
      send_beat(ONE_Q, '0, ONE_Q, 16'sd12867, '0, ONE_Q, '0, 0);
      send_beat(ONE_Q, '0, ONE_Q, -16'sd12867, '0, ONE_Q, '0, 0);
      send_beat(MAX_Q, MAX_Q, MAX_Q, MAX_Q, ONE_Q, '0, '0, 0);  // largest angle
      send_beat(MIN_Q, MIN_Q, MIN_Q, MIN_Q, '0, M_ONE_Q, '0, 2);
      send_beat(MAX_Q, MIN_Q, MAX_Q, 16'sd25736, '0, '0, M_ONE_Q, 0); // pi
      send_beat(16'sd1, '0, '0, '0, ONE_Q, '0, '0, 0);          // tiny vector
      send_beat('0, '0, 16'sd1, 16'sd3000, ONE_Q, '0, '0, 0);
      // non-unit axes: matrix terms saturate
      send_beat(ONE_Q, ONE_Q, ONE_Q, 16'sd5000, MAX_Q, MAX_Q, MAX_Q, 0);
      send_beat(ONE_Q, M_ONE_Q, ONE_Q, -16'sd20000, MIN_Q, MIN_Q, MIN_Q, 0);
      send_beat(MAX_Q, '0, MIN_Q, 16'sd9000, MIN_Q, MAX_Q, '0, 3);
      send_beat(ONE_Q, ONE_Q, ONE_Q, 16'sd100, '0, '0, '0, 0);  // zero axis
      send_beat(ONE_Q, '0, '0, 16'sd25736, ONE_Q, '0, '0, 0);   // rotation about itself
      send_beat(16'h5555, 16'haaaa, 16'h1234, 16'hedcb, 16'sd4730, 16'sd4730, 16'sd4730, 0);

      // random phase; in every 750 beats a 250-beat stretch without idling
      for (int n = 0; n < N_RANDOM; n++) begin
         rsp_stall_on = ((n / 250) % 3) != 2;
         rand_axis(ax, ay, az);
         case ($urandom_range(0, 9))
            0:       begin vx = '0; vy = '0; vz = '0; end
            1:       begin vx = $urandom_range(0, 3); vy = '0; vz = $urandom_range(0, 3); end
            default: begin vx = $urandom; vy = $urandom; vz = $urandom; end
         endcase
         ang = $urandom;
         send_beat(vx, vy, vz, ang, ax, ay, az, rsp_stall_on ? gap_len() : 0);
      end
      req_chan.valid = 1'b0;
      rsp_stall_on   = 1'b1;

      while (pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("** axis_angle_vector_rotate: PASSED **");
      end else begin
         $display("** axis_angle_vector_rotate: FAILED **");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #(12 * 1000000);
      $display("** axis_angle_vector_rotate: FAILED **");
      $finish;
   end
endmodule
